// ===== src/sbr_pkg.sv =====
package sbr_pkg;

  localparam int unsigned MaxBunch = 1024;

  localparam logic [1:0] RegBunchSize = 2'd0;
  localparam logic [1:0] RegPointMode = 2'd1;
  localparam logic [1:0] RegDistMode  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_ACCUM,
    ST_SQRT,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DIV_E,
    ST_OUT
  } sbr_state_t;

  // Iterative divider request
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
    logic        shift16;
  } sbr_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } sbr_div_rsp_t;

endpackage

// ===== src/sbr_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Quotient is floor(num * 2^16 / den) (shift16) or floor(num / den), capped at 2^33.
module sbr_div
  import sbr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  sbr_div_req_t req,
  output sbr_div_rsp_t rsp
);

  logic [79:0] dividend;
  logic [33:0] quo;
  logic [32:0] rem;
  logic [32:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        ovf;
  logic        done;
  logic [33:0] shifted;
  logic        fits;
  logic [33:0] quo_shift;

  assign shifted   = {rem, dividend[79]};
  assign fits      = shifted >= {1'b0, den};
  assign quo_shift = {quo[32:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        dividend <= req.shift16 ? {req.num, 16'd0} : {16'd0, req.num};
        den      <= req.den;
        rem      <= '0;
        quo      <= '0;
        ovf      <= 1'b0;
        cnt      <= 7'd79;
      end else if (busy) begin
        dividend <= {dividend[78:0], 1'b0};
        rem      <= fits ? 33'(shifted - {1'b0, den}) : shifted[32:0];
        // sticky cap once the quotient passes 2^33 - 1
        if (ovf || quo_shift > 34'h1FFFFFFFF) begin
          quo <= 34'h200000000;
          ovf <= 1'b1;
        end else begin
          quo <= quo_shift;
        end
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 7'd1;
      end
    end
  end

  assign rsp = '{done: done, quot: {30'd0, quo}};

endmodule

// ===== src/sbr_sqrt.sv =====
// Bitwise integer square root, one result bit per cycle.
module sbr_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] src;
  logic [33:0] rem;
  logic [31:0] res;
  logic [4:0]  cnt;
  logic        busy;
  logic [35:0] win;
  logic [35:0] trial;
  logic        fits;

  // Digit-by-digit: remainder window grows two bits per step.
  assign win   = {rem, src[63:62]};
  assign trial = {2'b00, res, 2'b01};
  assign fits  = win >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        src  <= val;
        rem  <= '0;
        res  <= '0;
        cnt  <= 5'd31;
      end else if (busy) begin
        src <= {src[61:0], 2'b00};
        if (fits) begin
          rem <= 34'(win - trial);
          res <= {res[30:0], 1'b1};
        end else begin
          rem <= win[33:0];
          res <= {res[30:0], 1'b0};
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 5'd1;
      end
    end
  end

  assign root = res;

endmodule

// ===== src/spectrum_bunch_rebinner_top.sv =====
// Spectrum bunch rebinner. Each accepted sample beat (x_left, x_right, y, e, last)
// is folded into saturating accumulators through one shared 34x34 multiplier in
// the steps accept, y term, e term and accumulate, with an extra pass in distribution
// mode where the capped e*|w| term is squared. A group closes after bunch_size
// samples or on tlast. Closing runs a 32-step square root and then the shared
// 80-step restoring divider (point mode: three divides for x, y, e; distribution
// mode: two, none on a zero total width). One result beat per group; s_tready is
// low while a sample is in work or a result waits.
module spectrum_bunch_rebinner_top
  import sbr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // x_left, x_right, y_in, e_in
  input  logic         s_tlast,   // last_in
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // x_low, x_high, y_out, e_out
  output logic         m_tlast,   // last_out
  output logic         m_tuser,   // width_error
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [10:0]  cfg_data
);

  logic [10:0] bunch_size;
  logic        point_mode;
  logic        dist_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      bunch_size <= 11'd1;
      point_mode <= 1'b0;
      dist_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegBunchSize: bunch_size <= cfg_data;
        RegPointMode: point_mode <= cfg_data[0];
        RegDistMode:  dist_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sbr_state_t state, state_next;

  logic signed [31:0] xl, xr, yi;
  logic [31:0] ei;
  logic        lst;
  logic [10:0] group_count;
  logic signed [47:0] x_accum;
  logic signed [63:0] y_accum;
  logic [63:0] err_sq_accum;
  logic signed [31:0] group_left_edge;

  logic               wmode;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [67:0] prod;
  logic signed [32:0] w;
  logic [32:0]        aw;
  logic signed [32:0] wt;
  logic [32:0]        awt;
  logic [10:0]        nb;
  logic [10:0]        count_inc;
  logic               closing;
  logic signed [63:0] y_term;
  logic [31:0]        e_cap;
  logic signed [64:0] ysum;
  logic signed [63:0] ysat;
  logic [64:0]        esum;
  logic [63:0]        y_mag;
  logic [47:0]        x_mag;
  logic               y_neg;
  logic               sq_start, sq_done;
  logic [31:0]        root;
  logic               launched;
  sbr_div_req_t       dreq;
  sbr_div_rsp_t       drsp;
  logic [63:0]        q_div;
  logic signed [64:0] q_s;
  logic [31:0]        r_xlo, r_xhi, r_y, r_e;
  logic               r_werr;

  sbr_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .val(err_sq_accum),
    .done(sq_done), .root(root)
  );

  sbr_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // bin-width weighting applies in distribution mode only, not to point data
  assign wmode = dist_mode && !point_mode;

  // shared multiplier, result registered in prod
  assign mul_p = mul_a * mul_b;

  assign w   = 33'(xr) - 33'(xl);
  assign aw  = w[32] ? unsigned'(33'(-w)) : unsigned'(w);
  assign wt  = 33'(xr) - 33'(group_left_edge);
  assign awt = wt[32] ? unsigned'(33'(-wt)) : unsigned'(wt);

  always_comb begin
    nb = bunch_size;
    if (nb == 11'd0) nb = 11'd1;
    if (nb > 11'(MaxBunch)) nb = 11'(MaxBunch);
  end

  assign count_inc = (group_count != 11'h7FF) ? group_count + 11'd1 : group_count;
  assign closing   = (count_inc >= nb) || lst;

  // floor shift of the signed y*w product; plain y otherwise
  assign y_term = wmode ? 64'(prod >>> 16) : 64'(prod);
  // e*|w|/2^16 capped at 32 bits
  assign e_cap  = (prod[63:48] != 16'd0) ? 32'hFFFFFFFF : prod[47:16];

  assign ysum = 65'(y_accum) + 65'(y_term);
  assign esum = {1'b0, err_sq_accum} + {1'b0, prod[63:0]};

  always_comb begin
    ysat = ysum[63:0];
    if (ysum[64] != ysum[63]) begin
      ysat = ysum[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    end
  end

  assign y_mag = y_accum[63] ? unsigned'(64'(-y_accum)) : unsigned'(y_accum);
  assign x_mag = x_accum[47] ? unsigned'(48'(-x_accum)) : unsigned'(x_accum);
  assign y_neg = point_mode ? y_accum[63] : (y_accum[63] != wt[32]);

  assign q_div = drsp.quot;
  assign q_s   = $signed({1'b0, q_div});

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sh07FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -65'sh080000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    sq_start = 1'b0;
    dreq = '0;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_MUL_A;
      ST_MUL_A: begin
        // y term: y (or y*w)
        mul_a = 34'(yi);
        mul_b = wmode ? 34'(w) : 34'sd1;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        // e*|w| when weighted, else e*e
        mul_a = 34'({1'b0, ei});
        mul_b = wmode ? 34'({1'b0, aw}) : 34'({1'b0, ei});
        state_next = wmode ? ST_MUL_C : ST_ACCUM;
      end
      ST_MUL_C: begin
        // square of the capped weighted error
        mul_a = 34'({2'b0, e_cap});
        mul_b = 34'({2'b0, e_cap});
        state_next = ST_ACCUM;
      end
      ST_ACCUM: state_next = closing ? ST_SQRT : ST_IDLE;
      ST_SQRT: begin
        sq_start = !launched;
        if (sq_done) begin
          if (point_mode) state_next = ST_DIV_X;
          else if (dist_mode && wt != 33'sd0) state_next = ST_DIV_Y;
          else state_next = ST_OUT;
        end
      end
      ST_DIV_X: begin
        dreq.start = !launched;
        dreq.num   = {16'd0, x_mag};
        dreq.den   = {22'd0, group_count};
        if (drsp.done) state_next = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        dreq.start   = !launched;
        dreq.num     = y_mag;
        dreq.den     = point_mode ? {22'd0, group_count} : awt;
        dreq.shift16 = !point_mode;
        if (drsp.done) state_next = ST_DIV_E;
      end
      ST_DIV_E: begin
        dreq.start   = !launched;
        dreq.num     = {32'd0, root};
        dreq.den     = point_mode ? {22'd0, group_count} : awt;
        dreq.shift16 = !point_mode;
        if (drsp.done) state_next = ST_OUT;
      end
      ST_OUT: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {r_e, r_y, r_xhi, r_xlo};
  assign m_tlast  = lst;
  assign m_tuser  = r_werr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      group_count     <= '0;
      x_accum         <= '0;
      y_accum         <= '0;
      err_sq_accum    <= '0;
      group_left_edge <= '0;
      launched        <= 1'b0;
    end else begin
      state <= state_next;
      // one start pulse per root or divide state
      launched <= (state_next == state) && (launched || sq_start || dreq.start);
      if (state == ST_IDLE && s_tvalid) begin
        xl  <= s_tdata[31:0];
        xr  <= s_tdata[63:32];
        yi  <= s_tdata[95:64];
        ei  <= s_tdata[127:96];
        lst <= s_tlast;
        if (group_count == 11'd0) group_left_edge <= s_tdata[31:0];
      end
      if (state == ST_MUL_A) begin
        prod <= mul_p;
        if (point_mode) x_accum <= x_accum + 48'(xl);
      end
      if (state == ST_MUL_B) begin
        y_accum <= ysat;
        prod    <= mul_p;
      end
      if (state == ST_MUL_C) prod <= mul_p;
      if (state == ST_ACCUM) begin
        err_sq_accum <= esum[64] ? '1 : esum[63:0];
        group_count  <= count_inc;
      end
      if (state == ST_SQRT && sq_done) begin
        r_xlo <= group_left_edge;
        r_xhi <= point_mode ? 32'd0 : xr;
        if (!point_mode && dist_mode && wt == 33'sd0) begin
          // zero total width: flag and saturate
          r_werr <= 1'b1;
          r_y    <= y_accum[63] ? 32'h80000000 : 32'h7FFFFFFF;
          r_e    <= 32'hFFFFFFFF;
        end else begin
          r_werr <= 1'b0;
          r_y    <= sat32(65'(y_accum));
          r_e    <= root;
        end
      end
      if (drsp.done) begin
        case (state)
          ST_DIV_X: r_xlo <= sat32(x_accum[47] ? -q_s : q_s);
          ST_DIV_Y: r_y   <= sat32(y_neg ? -q_s : q_s);
          ST_DIV_E: r_e   <= (q_div[63:32] != 32'd0) ? 32'hFFFFFFFF : q_div[31:0];
          default: ;
        endcase
      end
      if (state == ST_OUT && m_tready) begin
        group_count     <= '0;
        x_accum         <= '0;
        y_accum         <= '0;
        err_sq_accum    <= '0;
        group_left_edge <= '0;
      end
    end
  end

endmodule

// ===== test/spectrum_bunch_rebinner_top_test.sv =====
module spectrum_bunch_rebinner_top_test;
  import sbr_pkg::*;

  // One output bin as it leaves the block
  typedef struct packed {
    logic [31:0] x_low;
    logic [31:0] x_high;
    logic [31:0] y_out;
    logic [31:0] e_out;
    logic        last_o;
    logic        werr;
  } bin_t;

  typedef enum logic [1:0] {OP_BEAT, OP_CFG} op_t;

  // Directed stimulus row. For OP_CFG only idx/val matter. chk = 1 means the
  // expected bin is typed in the row, otherwise it comes from the predictor.
  typedef struct packed {
    op_t         op;
    logic [1:0]  idx;
    logic [10:0] val;
    logic [31:0] xl;
    logic [31:0] xr;
    logic [31:0] y;
    logic [31:0] e;
    logic        last;
    logic        chk;
    bin_t        want;
  } row_t;

  localparam int NRows = 26;
  localparam bin_t NoBin = '0;
  localparam row_t PLAN [NRows] = '{
    // histogram, bunch 1 right after reset: bin equals sample
    '{OP_BEAT, 2'd0, 11'd0, 32'h00010000, 32'h00020000, 32'h00050000, 32'h00030000, 1'b0,
      1'b1, '{32'h00010000, 32'h00020000, 32'h00050000, 32'h00030000, 1'b0, 1'b0}},
    '{OP_BEAT, 2'd0, 11'd0, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b1,
      1'b1, '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff, 1'b1, 1'b0}},
    '{OP_BEAT, 2'd0, 11'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h00000000, 1'b0,
      1'b1, '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h00000000, 1'b0, 1'b0}},
    '{OP_CFG, RegDistMode, 11'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NoBin},
    // zero total width; a zero-width bin adds nothing to the signal sum
    '{OP_BEAT, 2'd0, 11'd0, 32'h00010000, 32'h00010000, 32'h00020000, 32'h00000005, 1'b0,
      1'b1, '{32'h00010000, 32'h00010000, 32'h7fffffff, 32'hffffffff, 1'b0, 1'b1}},
    '{OP_BEAT, 2'd0, 11'd0, 32'h00000000, 32'h00000000, 32'h80000000, 32'h00000000, 1'b1,
      1'b1, '{32'h00000000, 32'h00000000, 32'h7fffffff, 32'hffffffff, 1'b1, 1'b1}},
    '{OP_BEAT, 2'd0, 11'd0, 32'h00000000, 32'h00020000, 32'h00010000, 32'h00010000, 1'b0,
      1'b0, NoBin},
    // negative width
    '{OP_BEAT, 2'd0, 11'd0, 32'h00030000, 32'h00010000, 32'hfff00000, 32'h00048000, 1'b0,
      1'b0, NoBin},
    '{OP_CFG, RegBunchSize, 11'd3, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NoBin},
    '{OP_BEAT, 2'd0, 11'd0, 32'h00000000, 32'h00008000, 32'h00100000, 32'h00001000, 1'b0,
      1'b0, NoBin},
    '{OP_BEAT, 2'd0, 11'd0, 32'h00008000, 32'h00010000, 32'h00200000, 32'h00002000, 1'b0,
      1'b0, NoBin},
    '{OP_BEAT, 2'd0, 11'd0, 32'h00010000, 32'h00020000, 32'hffe00000, 32'h00003000, 1'b0,
      1'b0, NoBin},
    // short group closed by last
    '{OP_BEAT, 2'd0, 11'd0, 32'h00020000, 32'h00030000, 32'h00010000, 32'h00010000, 1'b1,
      1'b0, NoBin},
    // bunch zero acts as one
    '{OP_CFG, RegBunchSize, 11'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NoBin},
    '{OP_BEAT, 2'd0, 11'd0, 32'hffff0000, 32'h00010000, 32'h7fffffff, 32'hffffffff, 1'b0,
      1'b0, NoBin},
    // bunch above the cap, point mode
    '{OP_CFG, RegBunchSize, 11'd2047, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NoBin},
    '{OP_CFG, RegPointMode, 11'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NoBin},
    '{OP_BEAT, 2'd0, 11'd0, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'hffffffff, 1'b0,
      1'b0, NoBin},
    '{OP_BEAT, 2'd0, 11'd0, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'hffffffff, 1'b0,
      1'b0, NoBin},
    '{OP_BEAT, 2'd0, 11'd0, 32'h80000001, 32'h0, 32'h80000000, 32'h00000003, 1'b1,
      1'b0, NoBin},
    '{OP_CFG, RegBunchSize, 11'd4, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NoBin},
    '{OP_BEAT, 2'd0, 11'd0, 32'hfffe0000, 32'h0, 32'hffff0001, 32'h00000007, 1'b0,
      1'b0, NoBin},
    '{OP_BEAT, 2'd0, 11'd0, 32'h00010000, 32'h0, 32'h00000002, 32'h00000009, 1'b0,
      1'b0, NoBin},
    // register change inside a group: group of 2 closes at size 1 on next beat
    '{OP_CFG, RegBunchSize, 11'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NoBin},
    '{OP_CFG, RegPointMode, 11'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, NoBin},
    '{OP_BEAT, 2'd0, 11'd0, 32'h00050000, 32'h00040000, 32'h00030000, 32'h00000011, 1'b0,
      1'b0, NoBin}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         m_tlast;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [10:0]  cfg_data = '0;

  // typed expectation travels with the beat so it lines up with acceptance
  logic         beat_typed = 1'b0;
  bin_t         beat_want = '0;

  always #6 clk = ~clk;

  spectrum_bunch_rebinner_top u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data
  );

  // predictor copy of registers and group sums
  logic [10:0]     cur_bunch = 11'd1;
  logic            cur_point = 1'b0;
  logic            cur_dist = 1'b0;
  int unsigned     grp_n = 0;
  longint          sum_x = 0;
  longint          sum_y = 0;
  longint unsigned sum_e2 = 0;
  longint          edge_l = 0;

  bin_t  bins_due [$];
  int    errors = 0;
  bit    idle_on = 1'b1;
  int    rx_hold = 0;
  int    sent = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic longint sadd64(input longint a, input longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'h7fff_ffff_ffff_ffff;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic longint unsigned uadd64(input longint unsigned a,
                                             input longint unsigned b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hffff_ffff_ffff_ffff : s[63:0];
  endfunction

  function automatic logic [31:0] sat32(input longint v);
    if (v > 64'sh7fffffff) return 32'h7fffffff;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // floor(num * 2^16 / d), capped at 2^33
  function automatic longint unsigned scaled_div(input longint unsigned num,
                                                 input longint unsigned d);
    longint unsigned r, q, b;
    r = 0;
    q = 0;
    for (int i = 79; i >= 0; i--) begin
      b = (i >= 16) ? ((num >> (i - 16)) & 1) : 0;
      r = (r << 1) | b;
      q <<= 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
      if (q > 64'h1_ffff_ffff) q = 64'h2_0000_0000;
    end
    return q;
  endfunction

  // fold one accepted sample into the group; returns 1 with the bin on close
  function automatic bit fold_sample(input logic [127:0] d, input logic last,
                                     output bin_t bin);
    longint xl, xr, y, w, wt, q;
    longint unsigned e, aw, et, rt, eo, ym, nb;
    bit neg;
    xl = longint'($signed(d[31:0]));
    xr = longint'($signed(d[63:32]));
    y = longint'($signed(d[95:64]));
    e = d[127:96];
    bin = '0;
    nb = cur_bunch;
    if (nb == 0) nb = 1;
    if (nb > MaxBunch) nb = MaxBunch;
    if (grp_n == 0) edge_l = xl;
    if (cur_point) begin
      sum_x += xl;
      sum_y = sadd64(sum_y, y);
      sum_e2 = uadd64(sum_e2, e * e);
    end else if (cur_dist) begin
      w = xr - xl;
      aw = (w < 0) ? -w : w;
      et = (e * aw) >> 16;
      if (et > 64'hffffffff) et = 64'hffffffff;
      sum_y = sadd64(sum_y, (y * w) >>> 16);
      sum_e2 = uadd64(sum_e2, et * et);
    end else begin
      sum_y = sadd64(sum_y, y);
      sum_e2 = uadd64(sum_e2, e * e);
    end
    if (grp_n < 2047) grp_n++;
    if (grp_n < nb && !last) return 1'b0;

    rt = root64(sum_e2);
    if (cur_point) begin
      bin.x_low = sat32(sum_x / longint'(grp_n));
      bin.y_out = sat32(sum_y / longint'(grp_n));
      eo = rt / grp_n;
    end else begin
      bin.x_low = edge_l[31:0];
      bin.x_high = xr[31:0];
      bin.y_out = sat32(sum_y);
      eo = rt;
      if (cur_dist) begin
        wt = xr - edge_l;
        if (wt == 0) begin
          bin.werr = 1'b1;
          bin.y_out = (sum_y >= 0) ? 32'h7fffffff : 32'h80000000;
          eo = 64'hffffffff;
        end else begin
          aw = (wt < 0) ? -wt : wt;
          neg = (sum_y < 0) != (wt < 0);
          ym = (sum_y < 0) ? 64'd0 - sum_y : sum_y;
          q = scaled_div(ym, aw);
          bin.y_out = sat32(neg ? -q : q);
          eo = scaled_div(rt, aw);
        end
      end
    end
    if (eo > 64'hffffffff) eo = 64'hffffffff;
    bin.e_out = eo[31:0];
    bin.last_o = last;
    grp_n = 0;
    sum_x = 0;
    sum_y = 0;
    sum_e2 = 0;
    edge_l = 0;
    return 1'b1;
  endfunction

  // input accept: predict; output accept: compare with oldest bin
  always @(posedge clk) begin
    bin_t pb, gb, wb;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        if (fold_sample(s_tdata, s_tlast, pb)) bins_due.push_back(beat_typed ? beat_want : pb);
      end
      if (m_tvalid && m_tready) begin
        gb = '{m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
               m_tlast, m_tuser};
        if (bins_due.size() == 0) begin
          report("unexpected bin x_low", gb.x_low, 32'h0);
        end else begin
          wb = bins_due.pop_front();
          if (gb.x_low !== wb.x_low) report("x_low", gb.x_low, wb.x_low);
          if (gb.x_high !== wb.x_high) report("x_high", gb.x_high, wb.x_high);
          if (gb.y_out !== wb.y_out) report("y_out", gb.y_out, wb.y_out);
          if (gb.e_out !== wb.e_out) report("e_out", gb.e_out, wb.e_out);
          if (gb.last_o !== wb.last_o) report("last_out", 32'(gb.last_o), 32'(wb.last_o));
          if (gb.werr !== wb.werr) report("width_error", 32'(gb.werr), 32'(wb.werr));
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // present one sample beat and hold it until accepted
  task automatic send_sample(input logic [31:0] xl, input logic [31:0] xr,
                             input logic [31:0] y, input logic [31:0] e,
                             input logic last, input logic typed, input bin_t want);
    s_tvalid <= 1'b1;
    s_tdata <= {e, y, xr, xl};
    s_tlast <= last;
    beat_typed <= typed;
    beat_want <= want;
    do @(posedge clk); while (!s_tready);
    sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // registers change only once the block has drained
  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bins_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegBunchSize: cur_bunch = val;
      RegPointMode: cur_point = val[0];
      RegDistMode:  cur_dist = val[0];
      default: ;
    endcase
  endtask

  // edge values often, random otherwise
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return 32'hffffffff;
      4: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int phase, len;
    logic [10:0] bsz;
    logic [31:0] pos, xl, xr;
    bit tidy;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NRows; i++) begin
      if (PLAN[i].op == OP_CFG) write_reg(PLAN[i].idx, PLAN[i].val);
      else send_sample(PLAN[i].xl, PLAN[i].xr, PLAN[i].y, PLAN[i].e, PLAN[i].last,
                       PLAN[i].chk, PLAN[i].want);
    end

    phase = 0;
    while (sent < 1200) begin
      case ($urandom_range(0, 9))
        0: bsz = 11'd0;
        1: bsz = 11'd1024;
        2: bsz = 11'd2047;
        3: bsz = 11'($urandom_range(0, 2047));
        default: bsz = 11'($urandom_range(1, 8));
      endcase
      write_reg(RegBunchSize, bsz);
      write_reg(RegPointMode, 11'($urandom_range(0, 1)));
      write_reg(RegDistMode, 11'($urandom_range(0, 2) != 0));
      if (phase == 3) rx_hold = 2000;   // long hold-off: block backs up
      if (sent > 1050) idle_on = 1'b0;
      for (int s = 0; s < 3; s++) begin
        len = $urandom_range(1, 40);
        tidy = $urandom_range(0, 9) != 0;
        pos = pick32();
        for (int k = 0; k < len; k++) begin
          if (tidy) begin
            xl = pos;
            xr = xl + (($urandom_range(0, 7) == 0) ? 32'h0 : $urandom_range(1, 32'h30000));
          end else begin
            xl = pick32();
            xr = pick32();
          end
          pos = xr;
          send_sample(xl, xr, pick32(), pick32(),
                      tidy ? (k == len - 1) : 1'($urandom_range(0, 7) == 0), 1'b0, NoBin);
        end
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && bins_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #36000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sbr_pkg.sv
src/sbr_div.sv
src/sbr_sqrt.sv
src/spectrum_bunch_rebinner_top.sv
test/spectrum_bunch_rebinner_top_test.sv
